@@ hdl/pvss_pkg.sv @@
// Shared types and constants for the packed voxel section store.
`default_nettype none

package pvss_pkg;

  // Field widths of one cell word and of the section counters
  localparam int unsigned ID_W    = 12;
  localparam int unsigned NIB_W   = 4;
  localparam int unsigned EXTRA_W = 8;
  localparam int unsigned WORD_W  = 32;
  localparam int unsigned CNT_W   = 13;
  localparam int unsigned IDX_W   = 12;

  // Cell word layout: extra[31:24] sky[23:20] block light[19:16] meta[15:12] id[11:0]
  localparam logic [WORD_W-1:0] DEFAULT_CELL = 32'h00F0_0000;
  localparam logic [NIB_W-1:0]  SKY_FULL     = 4'hF;

  typedef enum logic [2:0] {
    CMD_READ      = 3'd0,
    CMD_WR_ID     = 3'd1,
    CMD_WR_META   = 3'd2,
    CMD_WR_BLIGHT = 3'd3,
    CMD_WR_SKY    = 3'd4,
    CMD_WR_EXTRA  = 3'd5,
    CMD_WR_BLOCK  = 3'd6
  } cmd_e;

  typedef struct packed {
    logic [2:0]         command;
    logic [3:0]         x;
    logic [7:0]         y;
    logic [3:0]         z;
    logic [ID_W-1:0]    block_id;
    logic [NIB_W-1:0]   metadata;
    logic [NIB_W-1:0]   light_level;
    logic [EXTRA_W-1:0] extra_byte;
  } pvss_in_t;

  typedef struct packed {
    logic [ID_W-1:0]    out_block_id;
    logic [NIB_W-1:0]   out_meta;
    logic [NIB_W-1:0]   out_block_light;
    logic [NIB_W-1:0]   out_sky_light;
    logic [EXTRA_W-1:0] out_extra;
    logic               section_present;
    logic [CNT_W-1:0]   section_air;
    logic [CNT_W-1:0]   section_high_ids;
  } pvss_out_t;

  // Controller to datapath commands
  typedef struct packed {
    logic clr_wr;   // write the default word at the clear address
    logic load;     // capture an input beat
    logic rd_en;    // reduce the address and read the cell word
    logic commit;   // write back, update the section and load the result
  } pvss_ctl_t;

  // Datapath to controller status
  typedef struct packed {
    logic clear_last;
  } pvss_sts_t;

endpackage

`default_nettype wire

@@ hdl/pvss_ctrl.sv @@
// Controller state machine of the packed voxel section store.
`default_nettype none

module pvss_ctrl
  import pvss_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_ready_o,
  output logic           out_valid_o,
  input  wire logic      out_ready_i,
  input  wire pvss_sts_t sts_i,
  output pvss_ctl_t      ctl_o
);

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_ADDR  = 2'd2;
  localparam logic [1:0] ST_RMW   = 2'd3;

  logic [1:0] state_q, state_d;
  logic       out_vld_q, out_vld_d;
  logic       commit, load, in_rdy;

  // Finish the write-back only when the result register is free or draining
  assign commit = (state_q == ST_RMW) && (!out_vld_q || out_ready_i);
  assign in_rdy = (state_q == ST_IDLE) || commit;
  assign load   = in_valid_i && in_rdy;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: if (sts_i.clear_last) state_d = ST_IDLE;
      ST_IDLE:  if (load) state_d = ST_ADDR;
      ST_ADDR:  state_d = ST_RMW;
      ST_RMW: begin
        if (commit) state_d = load ? ST_ADDR : ST_IDLE;
      end
      default:  state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_vld_d = out_vld_q;
    if (commit) begin
      out_vld_d = 1'b1;
    end else if (out_ready_i) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      out_vld_q <= out_vld_d;
    end
  end

  assign ctl_o.clr_wr = (state_q == ST_CLEAR);
  assign ctl_o.load   = load;
  assign ctl_o.rd_en  = (state_q == ST_ADDR);
  assign ctl_o.commit = commit;

  assign in_ready_o  = in_rdy;
  assign out_valid_o = out_vld_q;

endmodule

`default_nettype wire

@@ hdl/pvss_dp.sv @@
// Datapath of the packed voxel section store: cell memory, section state, result register.
`default_nettype none

module pvss_dp
  import pvss_pkg::*;
#(
  parameter int unsigned SECTIONS      = 16,
  parameter int unsigned SECTION_CELLS = 4096
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire pvss_ctl_t ctl_i,
  output pvss_sts_t      sts_o,
  input  wire pvss_in_t  in_data_i,
  output pvss_out_t      out_data_o
);

  localparam int unsigned SEC_W     = (SECTIONS > 1) ? $clog2(SECTIONS) : 1;
  localparam int unsigned LOC_W     = $clog2(SECTION_CELLS);
  localparam int unsigned MEM_AW    = SEC_W + LOC_W;
  localparam int unsigned MEM_DEPTH = SECTIONS * (2 ** LOC_W);
  // Reciprocal for the cell index reduction; exact for every 12-bit index
  localparam int unsigned RCP_SH    = 25;
  localparam int unsigned RCP_W     = 26;
  localparam int unsigned Q_W       = 6;
  localparam logic [RCP_W-1:0] RCP  = RCP_W'(((2 ** RCP_SH) + SECTION_CELLS - 1)
                                             / SECTION_CELLS);
  localparam int unsigned PROD_W    = IDX_W + RCP_W;

  // Section number table: y upper nibble modulo SECTIONS
  logic [SEC_W-1:0] sec_lut [16];
  for (genvar g = 0; g < 16; g++) begin : g_sec_lut
    assign sec_lut[g] = SEC_W'(g % SECTIONS);
  end

  logic [WORD_W-1:0] mem [MEM_DEPTH];

  logic [MEM_AW-1:0]  clr_addr_q;
  logic [MEM_AW-1:0]  addr_q;
  logic [WORD_W-1:0]  rdata_q;
  logic [2:0]         cmd_q;
  logic [SEC_W-1:0]   sec_q;
  logic [IDX_W-1:0]   idx_q;
  logic [Q_W-1:0]     quo_q;
  logic [ID_W-1:0]    id_q;
  logic [NIB_W-1:0]   meta_q;
  logic [NIB_W-1:0]   light_q;
  logic [EXTRA_W-1:0] extra_q;
  pvss_out_t          out_q;

  logic [SECTIONS-1:0] present_q;
  logic [CNT_W-1:0]    air_q  [SECTIONS];
  logic [CNT_W-1:0]    high_q [SECTIONS];

  logic [IDX_W-1:0]  in_idx;
  logic [PROD_W-1:0] in_prod;
  logic [IDX_W-1:0]  quo_mul;
  logic [LOC_W-1:0]  loc;

  logic [ID_W-1:0]   old_id;
  logic              is_wr, is_dflt, id_chg, do_write;
  logic [WORD_W-1:0] new_word, res_word;
  logic [CNT_W-1:0]  air_nx, high_nx;

  assign in_idx  = {in_data_i.y[3:0], in_data_i.z, in_data_i.x};
  assign in_prod = PROD_W'(in_idx) * PROD_W'(RCP);
  assign quo_mul = IDX_W'(quo_q * SECTION_CELLS);
  assign loc     = LOC_W'(idx_q - quo_mul);

  assign sts_o.clear_last = (clr_addr_q == MEM_AW'(MEM_DEPTH - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_addr_q <= '0;
    end else if (ctl_i.clr_wr) begin
      clr_addr_q <= clr_addr_q + 1'b1;
    end
  end

  // Cell memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (ctl_i.clr_wr) begin
      mem[clr_addr_q] <= DEFAULT_CELL;
    end else if (ctl_i.commit && do_write) begin
      mem[addr_q] <= new_word;
    end
    if (ctl_i.rd_en) begin
      rdata_q <= mem[{sec_q, loc}];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      cmd_q   <= in_data_i.command;
      sec_q   <= sec_lut[in_data_i.y[7:4]];
      idx_q   <= in_idx;
      quo_q   <= in_prod[RCP_SH +: Q_W];
      id_q    <= in_data_i.block_id;
      meta_q  <= in_data_i.metadata;
      light_q <= in_data_i.light_level;
      extra_q <= in_data_i.extra_byte;
    end
    if (ctl_i.rd_en) begin
      addr_q <= {sec_q, loc};
    end
    if (ctl_i.commit) begin
      out_q.out_block_id     <= res_word[11:0];
      out_q.out_meta         <= res_word[15:12];
      out_q.out_block_light  <= res_word[19:16];
      out_q.out_sky_light    <= res_word[23:20];
      out_q.out_extra        <= res_word[31:24];
      out_q.section_present  <= present_q[sec_q] | do_write;
      out_q.section_air      <= air_nx;
      out_q.section_high_ids <= high_nx;
    end
  end

  always_comb begin
    old_id   = rdata_q[11:0];
    is_wr    = 1'b1;
    is_dflt  = 1'b1;
    id_chg   = 1'b0;
    new_word = rdata_q;
    unique case (cmd_q)
      CMD_WR_ID: begin
        is_dflt  = (id_q == '0);
        id_chg   = 1'b1;
        new_word = {{EXTRA_W{1'b0}}, rdata_q[23:12], id_q};
      end
      CMD_WR_META: begin
        is_dflt  = (meta_q == '0);
        new_word = {rdata_q[31:16], meta_q, rdata_q[11:0]};
      end
      CMD_WR_BLIGHT: begin
        is_dflt  = (light_q == '0);
        new_word = {rdata_q[31:20], light_q, rdata_q[15:0]};
      end
      CMD_WR_SKY: begin
        is_dflt  = (light_q == SKY_FULL);
        new_word = {rdata_q[31:24], light_q, rdata_q[19:0]};
      end
      CMD_WR_EXTRA: begin
        is_dflt  = (extra_q == '0);
        new_word = {extra_q, rdata_q[23:0]};
      end
      CMD_WR_BLOCK: begin
        is_dflt  = (id_q == '0) && (extra_q == '0);
        id_chg   = 1'b1;
        new_word = {extra_q, rdata_q[23:16], meta_q, id_q};
      end
      default: begin
        is_wr = 1'b0;
      end
    endcase

    // Drop default writes to an absent section
    do_write = is_wr && (present_q[sec_q] || !is_dflt);
    res_word = do_write ? new_word : rdata_q;

    air_nx  = air_q[sec_q];
    high_nx = high_q[sec_q];
    if (do_write && id_chg) begin
      if ((old_id != '0) && (id_q == '0)) begin
        air_nx = air_nx + 1'b1;
      end else if ((old_id == '0) && (id_q != '0)) begin
        air_nx = air_nx - 1'b1;
      end
      if ((old_id[11:8] != '0) && (id_q[11:8] == '0)) begin
        high_nx = high_nx - 1'b1;
      end else if ((old_id[11:8] == '0) && (id_q[11:8] != '0)) begin
        high_nx = high_nx + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      present_q <= '0;
      for (int i = 0; i < SECTIONS; i++) begin
        air_q[i]  <= CNT_W'(SECTION_CELLS);
        high_q[i] <= '0;
      end
    end else if (ctl_i.commit && do_write) begin
      present_q[sec_q] <= 1'b1;
      air_q[sec_q]     <= air_nx;
      high_q[sec_q]    <= high_nx;
    end
  end

  assign out_data_o = out_q;

endmodule

`default_nettype wire

@@ hdl/packed_voxel_section_store.sv @@
// Each accepted beat reads its cell word, then writes it back; the result beat then turns valid.
// The next beat is taken in the write-back cycle; a stalled output holds write-back.
// After reset a clearing pass writes the default word to every memory entry, one per cycle:
// SECTIONS * 2**ceil(log2(SECTION_CELLS)) entries (65536 at the defaults), with input ready held low.
// Section flags and counters reset at once; the result register needs no reset.
`default_nettype none

module packed_voxel_section_store
  import pvss_pkg::*;
#(
  parameter int unsigned SECTIONS      = 16,
  parameter int unsigned SECTION_CELLS = 4096
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_ready_o,
  input  wire pvss_in_t in_data_i,
  output logic          out_valid_o,
  input  wire logic     out_ready_i,
  output pvss_out_t     out_data_o
);

  // Controller and datapath talk only through these two groups
  pvss_ctl_t ctl;
  pvss_sts_t sts;

  // Sequence: clear pass, then per beat: capture and reduce index, read cell, write back
  pvss_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .ctl_o       (ctl)
  );

  // Hold the cell memory, the section flags and counters, and the result register
  pvss_dp #(
    .SECTIONS      (SECTIONS),
    .SECTION_CELLS (SECTION_CELLS)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (ctl),
    .sts_o      (sts),
    .in_data_i  (in_data_i),
    .out_data_o (out_data_o)
  );

`ifndef SYNTHESIS
  // No beat is taken while the clearing pass still runs
  a_no_accept_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl.clr_wr |-> !in_ready_o)
    else $error("input ready during clearing pass");

  // The cell read always follows a captured beat
  a_read_after_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl.rd_en |-> $past(ctl.load))
    else $error("cell read without a captured beat");

  // A result beat appears only after a write-back
  a_out_after_commit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(ctl.commit))
    else $error("result beat without write-back");
`endif

endmodule

`default_nettype wire

@@ dv/testbench.sv @@
// Self-checking testbench for the packed voxel section store.
`default_nettype none

module testbench;
  import pvss_pkg::*;

  localparam int unsigned SECTIONS       = 16;
  localparam int unsigned SECTION_CELLS  = 4096;
  localparam int unsigned STORE_CELLS    = SECTIONS * SECTION_CELLS;
  // The unused command code; the block treats it as a read
  localparam logic [2:0]  CMD_SPARE      = 3'd7;
  localparam int unsigned RANDOM_ITEMS   = 500;
  // Sections 13..15 only see default-valued writes until this random item
  localparam int unsigned SHELTER_UNTIL  = 400;
  // Receiver holds off once, this long, so the block backs up into its input
  localparam int unsigned HOLD_AT_RESULT = 150;
  localparam int unsigned HOLD_CYCLES    = 300;
  // Long enough to cover the quiet clearing pass after reset
  localparam int unsigned WATCHDOG_LIMIT = 250000;
  localparam int unsigned DRAIN_CYCLES   = 10;

  // Mirror of the store: cell words, section flags and counters, and the
  // queue of cells and counters the block should report next.
  class voxel_mirror;
    bit [31:0]        cell_words [STORE_CELLS];
    bit               present    [SECTIONS];
    bit [CNT_W-1:0]   air_cells  [SECTIONS];
    bit [CNT_W-1:0]   high_count [SECTIONS];
    pvss_out_t        pending_cells[$];
    int unsigned      errors;

    function new();
      foreach (cell_words[i]) cell_words[i] = DEFAULT_CELL;
      foreach (present[s]) begin
        present[s]    = 1'b0;
        air_cells[s]  = CNT_W'(SECTION_CELLS);
        high_count[s] = '0;
      end
      errors = 0;
    endfunction

    // Replace the id of a cell word and keep the section counters in step
    function bit [31:0] swap_id(bit [3:0] sec, bit [31:0] word, bit [ID_W-1:0] id);
      if (word[11:0] != 0 && id == 0) air_cells[sec] = air_cells[sec] + 1'b1;
      else if (word[11:0] == 0 && id != 0) air_cells[sec] = air_cells[sec] - 1'b1;
      if (word[11:8] != 0 && id[11:8] == 0) high_count[sec] = high_count[sec] - 1'b1;
      else if (word[11:8] == 0 && id[11:8] != 0) high_count[sec] = high_count[sec] + 1'b1;
      return {word[31:12], id};
    endfunction

    // Apply one accepted command beat and queue the result it must produce
    function void note_command(pvss_in_t c);
      bit [3:0]  sec;
      bit [15:0] addr;
      bit [31:0] word;
      bit        is_default;
      bit        is_write;
      pvss_out_t r;
      sec        = c.y[7:4];
      addr       = {c.y, c.z, c.x};
      word       = cell_words[addr];
      is_write   = (c.command != CMD_READ) && (c.command != CMD_SPARE);
      is_default = 1'b1;
      case (c.command)
        CMD_WR_ID:     is_default = (c.block_id == 0);
        CMD_WR_META:   is_default = (c.metadata == 0);
        CMD_WR_BLIGHT: is_default = (c.light_level == 0);
        CMD_WR_SKY:    is_default = (c.light_level == SKY_FULL);
        CMD_WR_EXTRA:  is_default = (c.extra_byte == 0);
        CMD_WR_BLOCK:  is_default = (c.block_id == 0) && (c.extra_byte == 0);
        default: ;
      endcase
      // Drop default-valued writes while the section is still absent
      if (is_write && (present[sec] || !is_default)) begin
        present[sec] = 1'b1;
        case (c.command)
          CMD_WR_ID: begin
            word = swap_id(sec, word, c.block_id);
            word[31:24] = '0;
          end
          CMD_WR_META:   word[15:12] = c.metadata;
          CMD_WR_BLIGHT: word[19:16] = c.light_level;
          CMD_WR_SKY:    word[23:20] = c.light_level;
          CMD_WR_EXTRA:  word[31:24] = c.extra_byte;
          CMD_WR_BLOCK: begin
            word[15:12] = c.metadata;
            word = swap_id(sec, word, c.block_id);
            word[31:24] = c.extra_byte;
          end
          default: ;
        endcase
        cell_words[addr] = word;
      end
      r.out_block_id     = word[11:0];
      r.out_meta         = word[15:12];
      r.out_block_light  = word[19:16];
      r.out_sky_light    = word[23:20];
      r.out_extra        = word[31:24];
      r.section_present  = present[sec];
      r.section_air      = air_cells[sec];
      r.section_high_ids = high_count[sec];
      pending_cells.push_back(r);
    endfunction

    function bit field_ok(string name, logic [CNT_W-1:0] want, logic [CNT_W-1:0] got);
      if (got !== want) begin
        $display("%0t  %s: expected %0h, got %0h", $time, name, want, got);
        return 1'b0;
      end
      return 1'b1;
    endfunction

    // Compare one result beat with the oldest queued cell, field by field
    function void check_result(pvss_out_t got);
      pvss_out_t want;
      bit        ok;
      if (pending_cells.size() == 0) begin
        $display("%0t  result beat with nothing expected: got %h", $time, got);
        errors++;
        return;
      end
      want = pending_cells.pop_front();
      ok = 1'b1;
      ok &= field_ok("out_block_id",     want.out_block_id,     got.out_block_id);
      ok &= field_ok("out_meta",         want.out_meta,         got.out_meta);
      ok &= field_ok("out_block_light",  want.out_block_light,  got.out_block_light);
      ok &= field_ok("out_sky_light",    want.out_sky_light,    got.out_sky_light);
      ok &= field_ok("out_extra",        want.out_extra,        got.out_extra);
      ok &= field_ok("section_present",  want.section_present,  got.section_present);
      ok &= field_ok("section_air",      want.section_air,      got.section_air);
      ok &= field_ok("section_high_ids", want.section_high_ids, got.section_high_ids);
      if (!ok) errors++;
    endfunction

    function int unsigned pending();
      return pending_cells.size();
    endfunction
  endclass

  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      in_valid    = 1'b0;
  logic      in_ready_o;
  pvss_in_t  in_data     = '0;
  logic      out_valid_o;
  logic      out_ready   = 1'b0;
  pvss_out_t out_data_o;

  voxel_mirror mirror = new();

  always #1 clk_i = ~clk_i;

  packed_voxel_section_store #(
    .SECTIONS      (SECTIONS),
    .SECTION_CELLS (SECTION_CELLS)
  ) i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready),
    .out_data_o  (out_data_o)
  );

  function automatic pvss_in_t beat_of(logic [2:0] cmd, logic [3:0] x, logic [7:0] y,
                                       logic [3:0] z, logic [ID_W-1:0] id,
                                       logic [NIB_W-1:0] meta, logic [NIB_W-1:0] light,
                                       logic [EXTRA_W-1:0] extra);
    pvss_in_t b;
    b.command     = cmd;
    b.x           = x;
    b.y           = y;
    b.z           = z;
    b.block_id    = id;
    b.metadata    = meta;
    b.light_level = light;
    b.extra_byte  = extra;
    return b;
  endfunction

  // Build one random command beat. Most beats land on a handful of hot cells
  // per section so that reads and rewrites meet earlier writes.
  function automatic pvss_in_t random_beat(int unsigned n);
    pvss_in_t    b;
    int unsigned pick;
    bit          want_default;
    b.x           = 4'($urandom_range(0, 15));
    b.y           = 8'($urandom_range(0, 255));
    b.z           = 4'($urandom_range(0, 15));
    b.block_id    = 12'($urandom_range(0, 4095));
    b.metadata    = 4'($urandom_range(0, 15));
    b.light_level = 4'($urandom_range(0, 15));
    b.extra_byte  = 8'($urandom_range(0, 255));
    pick = $urandom_range(0, 99);
    if (pick < 5) b.command = CMD_SPARE;
    else if (pick < 20) b.command = CMD_READ;
    else b.command = 3'($urandom_range(int'(CMD_WR_ID), int'(CMD_WR_BLOCK)));
    // Mix low ids and ids with a nonzero upper nibble to move both counters
    case ($urandom_range(0, 3))
      0: b.block_id = 12'($urandom_range(1, 255));
      1: b.block_id = 12'($urandom_range(256, 4095));
      default: ;
    endcase
    if ($urandom_range(0, 9) < 7) begin
      b.x[3:1] = '0;
      b.z[3:1] = '0;
      b.y[3:1] = '0;
    end
    want_default = ($urandom_range(0, 4) == 0);
    if (n < SHELTER_UNTIL) begin
      // Keep the top sections absent: only default-valued writes go there
      if ($urandom_range(0, 9) == 0) begin
        b.y[7:4] = 4'($urandom_range(13, 15));
        b.command = 3'($urandom_range(int'(CMD_WR_ID), int'(CMD_WR_BLOCK)));
        want_default = 1'b1;
      end else begin
        b.y[7:4] = 4'($urandom_range(0, 12));
      end
    end
    if (want_default) begin
      case (b.command)
        CMD_WR_ID:     b.block_id = '0;
        CMD_WR_META:   b.metadata = '0;
        CMD_WR_BLIGHT: b.light_level = '0;
        CMD_WR_SKY:    b.light_level = SKY_FULL;
        CMD_WR_EXTRA:  b.extra_byte = '0;
        CMD_WR_BLOCK: begin
          b.block_id   = '0;
          b.extra_byte = '0;
        end
        default: ;
      endcase
    end
    return b;
  endfunction

  // Offer one beat after a random gap and hold it until accepted. Every third
  // stretch of 40 beats goes back to back.
  task automatic send_beat(input pvss_in_t b, input int unsigned n);
    int unsigned gap;
    gap = (((n / 40) % 3) == 2) ? 0 : $urandom_range(0, 9);
    @(negedge clk_i);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_data  <= b;
    in_valid <= 1'b1;
    do @(posedge clk_i); while (in_ready_o !== 1'b1);
    mirror.note_command(b);
  endtask

  // Result side: stall at random, once for a long stretch, and check each beat
  initial begin : result_side
    int unsigned gap;
    int unsigned seen;
    seen = 0;
    forever begin
      if (seen == HOLD_AT_RESULT) gap = HOLD_CYCLES;
      else if (((seen / 32) % 3) == 1) gap = 0;
      else gap = $urandom_range(0, 9);
      @(negedge clk_i);
      if (gap != 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      out_ready <= 1'b1;
      do @(posedge clk_i); while (out_valid_o !== 1'b1);
      mirror.check_result(out_data_o);
      seen++;
    end
  end

  // Watchdog: end the run after too many cycles without any beat
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid === 1'b1 && in_ready_o === 1'b1) ||
          (out_valid_o === 1'b1 && out_ready === 1'b1)) quiet = 0;
      else quiet++;
    end
    $display("end of test: mismatches");
    $finish;
  end

  initial begin : stimulus
    pvss_in_t plan[$];
    // Hold reset, then release it on a falling edge
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Absent section 0: read, then every default-valued write must drop
    plan.push_back(beat_of(CMD_READ,      0,   0,  0,    0,  0,  0,   0));
    plan.push_back(beat_of(CMD_WR_ID,     0,   0,  0,    0,  9,  3,   0));
    plan.push_back(beat_of(CMD_WR_META,   0,   0,  0,    5,  0,  3,   0));
    plan.push_back(beat_of(CMD_WR_BLIGHT, 0,   0,  0,    5,  9,  0,   0));
    plan.push_back(beat_of(CMD_WR_SKY,    0,   0,  0,    5,  9, 15,   0));
    plan.push_back(beat_of(CMD_WR_EXTRA,  0,   0,  0,    5,  9,  3,   0));
    plan.push_back(beat_of(CMD_WR_BLOCK,  0,   0,  0,    0, 15,  3,   0));
    // Extreme values into the far corner of section 0 make it present
    plan.push_back(beat_of(CMD_WR_ID,     15, 15, 15, 4095,  0,  0, 255));
    plan.push_back(beat_of(CMD_WR_META,   15, 15, 15,    0, 15,  0,   0));
    plan.push_back(beat_of(CMD_WR_BLIGHT, 15, 15, 15,    0,  0, 15,   0));
    plan.push_back(beat_of(CMD_WR_SKY,    15, 15, 15,    0,  0,  0,   0));
    plan.push_back(beat_of(CMD_WR_EXTRA,  15, 15, 15,    0,  0,  0, 255));
    // Id drops below the upper nibble, clears extra, then goes back to air
    plan.push_back(beat_of(CMD_WR_ID,     15, 15, 15,  255,  0,  0, 255));
    plan.push_back(beat_of(CMD_WR_ID,     15, 15, 15,    0,  0,  0,   0));
    plan.push_back(beat_of(CMD_WR_BLOCK,  15, 15, 15,  256,  5,  0, 170));
    // Default values are stored once the section is present
    plan.push_back(beat_of(CMD_WR_SKY,    15, 15, 15,    0,  0, 15,   0));
    plan.push_back(beat_of(CMD_WR_META,   15, 15, 15,    0,  0,  0,   0));
    plan.push_back(beat_of(CMD_WR_BLOCK,  15, 15, 15,    0,  0,  0,   0));
    // Unused command code reads
    plan.push_back(beat_of(CMD_SPARE,     15, 15, 15, 4095, 15, 15, 255));
    // Top section: dropped sky write, then a read at the highest address
    plan.push_back(beat_of(CMD_WR_SKY,    15, 255, 15, 4095, 15, 15, 255));
    plan.push_back(beat_of(CMD_READ,      15, 255, 15,    0,  0,  0,   0));
    // Whole-block writes that are not default through extra or id alone
    plan.push_back(beat_of(CMD_WR_BLOCK,  3,  16,  7,    0,  0,  0,   1));
    plan.push_back(beat_of(CMD_WR_BLOCK,  3,  32,  7,    1,  0,  0,   0));
    foreach (plan[i]) send_beat(plan[i], i);

    for (int unsigned n = 0; n < RANDOM_ITEMS; n++) send_beat(random_beat(n), n);
    @(negedge clk_i);
    in_valid <= 1'b0;

    // Drain: wait out every queued result, then keep watching for strays
    while (mirror.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mirror.errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

`default_nettype wire
